/* design/ccx_pkg.sv */
package ccx_pkg;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        final_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_payload;
    logic [3:0]  valid_bytes;
    logic        is_last;
  } out_item_t;

  // job handed from front to back
  // slot is wide enough for one-byte items (64 slots per block)
  typedef struct packed {
    logic [31:0] counter;
    logic        new_block;
    logic [5:0]  slot;
    in_item_t    item;
  } job_t;

  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;
  localparam logic [2:0] REG_CTR     = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

  function automatic state_t quarter(input state_t s, input int a, input int b,
                                     input int c, input int d);
    state_t w;
    w = s;
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    quarter = w;
  endfunction

  function automatic state_t column_round(input state_t s);
    state_t w;
    w = quarter(s, 0, 4, 8, 12);
    w = quarter(w, 1, 5, 9, 13);
    w = quarter(w, 2, 6, 10, 14);
    column_round = quarter(w, 3, 7, 11, 15);
  endfunction

  function automatic state_t diag_round(input state_t s);
    state_t w;
    w = quarter(s, 0, 5, 10, 15);
    w = quarter(w, 1, 6, 11, 12);
    w = quarter(w, 2, 7, 8, 13);
    diag_round = quarter(w, 3, 4, 9, 14);
  endfunction

endpackage

/* design/ccx_front.sv */
module ccx_front #(
  parameter int SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  ccx_pkg::in_item_t in_item,
  input  logic [31:0]     initial_counter,
  output logic            job_valid,
  input  logic            job_ready,
  output ccx_pkg::job_t   job
);
  import ccx_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]   block_counter;
  logic [SW-1:0] slot_position;
  logic          message_active;
  logic [31:0]   ctr_use;
  logic [SW-1:0] slot_use;
  logic          take;

  assign full = job_valid && !job_ready;
  assign take = push && !full;
  assign ctr_use  = message_active ? block_counter : initial_counter;
  assign slot_use = message_active ? slot_position : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      slot_position <= '0;
      message_active <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_ready || !job_valid) job_valid <= take;
      if (take) begin
        job.item <= in_item;
        job.counter <= ctr_use;
        job.new_block <= (slot_use == '0);
        job.slot <= 6'(slot_use);
        block_counter <= (slot_use == '0) ? ctr_use + 32'd1 : ctr_use;
        slot_position <= (32'(slot_use) == SLOTS - 1) ? '0 : slot_use + SW'(1);
        message_active <= !in_item.final_item;
      end
    end
  end
endmodule

/* design/ccx_core.sv */
module ccx_core #(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  ccx_pkg::job_t   job,
  input  logic [255:0]    key,
  input  logic [95:0]     nonce,
  output logic            res_valid,
  input  logic            res_ready,
  output ccx_pkg::out_item_t res
);
  import ccx_pkg::*;

  localparam int STAGES = 2 * DOUBLE_ROUNDS;
  localparam int LANES = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;

  // pipeline advances only when output is free
  logic   adv;
  logic   v    [STAGES+1];
  job_t   j    [STAGES+1];
  state_t w    [STAGES+1];
  state_t init [STAGES+1];
  state_t seed;
  logic [511:0] ks, ks_cur;
  logic [3:0]   cnt;
  logic [63:0]  mixed;

  assign adv = !res_valid || res_ready;
  assign job_ready = adv;

  always_comb begin
    seed[0] = SIGMA0; seed[1] = SIGMA1; seed[2] = SIGMA2; seed[3] = SIGMA3;
    for (int i = 0; i < 8; i++) seed[4+i] = key[32*i +: 32];
    seed[12] = job.counter;
    for (int i = 0; i < 3; i++) seed[13+i] = nonce[32*i +: 32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STAGES; s++) v[s] <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v[0] <= job_valid;
      for (int s = 1; s <= STAGES; s++) v[s] <= v[s-1];
      res_valid <= v[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j[0] <= job; w[0] <= seed; init[0] <= seed;
      for (int s = 1; s <= STAGES; s++) begin
        j[s] <= j[s-1]; init[s] <= init[s-1];
        w[s] <= (s % 2 == 1) ? column_round(w[s-1]) : diag_round(w[s-1]);
      end
      if (v[STAGES] && j[STAGES].new_block) ks <= ks_cur;
      res.cipher_payload <= mixed;
      res.valid_bytes <= j[STAGES].item.byte_count;
      res.is_last <= j[STAGES].item.final_item;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) ks_cur[32*i +: 32] = w[STAGES][i] + init[STAGES][i];
  end

  always_comb begin
    logic [511:0] blk;
    logic [8:0]   base;
    blk = j[STAGES].new_block ? ks_cur : ks;
    cnt = (j[STAGES].item.byte_count > 4'(LANES)) ? 4'(LANES)
                                                 : j[STAGES].item.byte_count;
    base = 9'(j[STAGES].slot) * 9'(BYTES_PER_ITEM);
    mixed = '0;
    for (int i = 0; i < 8; i++)
      if (4'(i) < cnt)
        mixed[8*i +: 8] = j[STAGES].item.payload[8*i +: 8]
                          ^ blk[8*((6'(base) + 6'(i))) +: 8];
  end
endmodule

/* design/chacha20_stream_xor_top.sv */
// registered path from the accepting edge to the result on the ports:
// job register, seed stage, one round per stage, output register
// throughput: one item per cycle while the output is free, one round per pipeline stage
// a fresh 64-byte block is made for every slot-zero item in the round pipeline
// reset (rst, synchronous) clears configuration, valid flags, counter, slot and message state
module chacha20_stream_xor_top #(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ccx_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output ccx_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import ccx_pkg::*;

  logic [255:0] key;
  logic [63:0]  nonce_lo;
  logic [31:0]  nonce_hi;
  logic [31:0]  initial_counter;
  logic         job_valid, job_ready, res_valid;
  job_t         job;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; nonce_lo <= '0; nonce_hi <= '0; initial_counter <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY01:   key[63:0]    <= cfg_data;
        REG_KEY23:   key[127:64]  <= cfg_data;
        REG_KEY45:   key[191:128] <= cfg_data;
        REG_KEY67:   key[255:192] <= cfg_data;
        REG_NONCE01: nonce_lo     <= cfg_data;
        REG_NONCE2:  nonce_hi     <= cfg_data[31:0];
        REG_CTR:     initial_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front: counter and slot bookkeeping
  ccx_front #(.SLOTS(64 / BYTES_PER_ITEM)) u_front (
    .clk, .rst, .push, .full, .in_item, .initial_counter,
    .job_valid, .job_ready, .job
  );

  // back: round pipeline and xor
  ccx_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS), .BYTES_PER_ITEM(BYTES_PER_ITEM)) u_core (
    .clk, .rst, .job_valid, .job_ready, .job, .key,
    .nonce({nonce_hi, nonce_lo}), .res_valid, .res_ready(pop), .res(out_item)
  );

  assign empty = !res_valid;
endmodule
